// ===== rtl/mlp_pkg.sv =====
// Shared types, sizes and the tanh lookup table for the MLP predictor.
package mlp_pkg;

  localparam int MAX_FEATURES = 16;
  localparam int MAX_NEURONS  = 16;
  localparam int TANH_POINTS  = 256;
  localparam int TANH_LOG2    = $clog2(TANH_POINTS);

  localparam int STORE_DEPTH  = MAX_NEURONS * (MAX_FEATURES + 2);
  localparam int ADDR_W       = $clog2(STORE_DEPTH);
  localparam int CFG_W        = 5;
  localparam int K_W          = (MAX_NEURONS > 1) ? $clog2(MAX_NEURONS) : 1;
  localparam int CNT_W        = $clog2(MAX_NEURONS + 1);
  localparam int FC_W         = $clog2(MAX_FEATURES + 1);
  localparam int STRIDE_W     = $clog2(MAX_FEATURES + 3);
  localparam int VAL_W        = 16;
  localparam int ACC_W        = 40;
  localparam int Z_W          = ACC_W + 1;
  localparam int O_W          = 28;
  localparam int FRAC_W       = O_W - TANH_LOG2;
  localparam int TH_W         = 14;
  localparam int DG_W         = TH_W + 1 + FRAC_W + 1;
  localparam int TOT_W        = 34;
  localparam int PRED_W       = 24;
  localparam int TAB_IDX_W    = $clog2(TANH_POINTS + 1);

  // Register indexes on the configuration port
  localparam logic REG_NUM_FEATURES = 1'b0;
  localparam logic REG_NUM_NEURONS  = 1'b1;

  typedef enum logic [1:0] {
    KIND_WRITE,
    KIND_FEATURE
  } kind_e;

  typedef struct packed {
    kind_e                    kind;
    logic [ADDR_W-1:0]        idx;
    logic signed [VAL_W-1:0]  value;
  } req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FEAT,
    ST_RD_OUT,
    ST_RD_BIAS,
    ST_Z,
    ST_LUT,
    ST_TANH,
    ST_MUL,
    ST_SUM,
    ST_OUT
  } state_e;

  typedef logic signed [TH_W-1:0] tanh_tab_t [TANH_POINTS+1];

  // Shift-and-subtract quotient, only used while building the table
  function automatic longint unsigned udiv(longint unsigned num, longint unsigned den);
    logic [64:0]     rem;
    longint unsigned quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // One grid point: tanh(|x|) = (1-E)/(1+E), E = (1/e^v)^16, worked in Q.28, returned in Q.12
  function automatic int grid_tanh(int unsigned i);
    longint unsigned one;
    longint unsigned n;
    longint unsigned ii;
    longint unsigned d;
    longint unsigned v;
    longint unsigned sum;
    longint unsigned term;
    longint unsigned e;
    int t;
    one  = 64'd1 << 28;
    n    = TANH_POINTS;
    ii   = i;
    d    = (2 * ii >= n) ? 2 * ii - n : n - 2 * ii;
    v    = udiv(d << 28, n);
    sum  = one;
    term = one;
    for (int k = 1; k <= 20; k++) begin
      term = udiv((term * v) >> 28, longint'(k));
      sum  = sum + term;
    end
    e = udiv(one << 28, sum);
    for (int k = 0; k < 4; k++) begin
      e = (e * e) >> 28;
    end
    t = int'(udiv(((one - e) << 12) + ((one + e) >> 1), one + e));
    return (2 * ii < n) ? -t : t;
  endfunction

  function automatic tanh_tab_t build_tanh();
    tanh_tab_t r;
    for (int i = 0; i <= TANH_POINTS; i++) begin
      r[i] = TH_W'(grid_tanh(i));
    end
    return r;
  endfunction

  localparam tanh_tab_t TANH_TAB = build_tanh();

endpackage

// ===== rtl/mlp_one_hidden_layer_predict_top.sv =====
// Top level of the one-hidden-layer tanh MLP predictor.
//
// Usage:
//   Request channel: drive start_i with mode_i, weight_index_i and value_i;
//   a request is taken at a clock edge with start_i high and busy_o low.
//   mode_i = 0 writes one Q4.12 weight word (indexes past the store are
//   dropped), mode_i = 1 delivers the next feature of the current row.
//   Configuration: cfg_we_i writes num_features (index 0) or num_neurons
//   (index 1) at once; write only while the block is idle.
//   Result: after a row's last feature, valid_o pulses for one cycle with
//   prediction_o (Q12.12) and saturated_o; the receiver cannot stall.
// Flow:
//   Requests go through a two-entry queue into the back end, so busy_o rises
//   only when both entries are held. The back end reads a feature's weights
//   neuron by neuron through the single weight-store read port shared by all
//   neurons, and takes no new request until that is done. The last feature
//   of a row then runs the tanh/output pass, one neuron at a time, before
//   valid_o.
// Reset: clears the queue, accumulators, feature count and sets both
//   registers to 1; the weight store keeps no reset and must be loaded.
module mlp_one_hidden_layer_predict_top import mlp_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic                     mode_i,
  input  logic [8:0]               weight_index_i,
  input  logic signed [VAL_W-1:0]  value_i,
  input  logic                     cfg_we_i,
  input  logic                     cfg_index_i,
  input  logic [CFG_W-1:0]         cfg_wdata_i,
  output logic                     valid_o,
  output logic signed [PRED_W-1:0] prediction_o,
  output logic                     saturated_o
);

  // queued request between the two halves
  logic req_valid;
  logic req_ready;
  req_t req;

  mlp_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .mode_i         (mode_i),
    .weight_index_i (weight_index_i),
    .value_i        (value_i),
    .req_valid_o    (req_valid),
    .req_o          (req),
    .req_ready_i    (req_ready)
  );

  mlp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .req_valid_i  (req_valid),
    .req_i        (req),
    .req_ready_o  (req_ready),
    .valid_o      (valid_o),
    .prediction_o (prediction_o),
    .saturated_o  (saturated_o)
  );

endmodule

// ===== rtl/mlp_front.sv =====
// Front end: takes requests, drops out-of-range weight writes, queues the rest.
module mlp_front import mlp_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic                    mode_i,
  input  logic [8:0]              weight_index_i,
  input  logic signed [VAL_W-1:0] value_i,
  output logic                    req_valid_o,
  output req_t                    req_o,
  input  logic                    req_ready_i
);

  req_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       full;
  logic       accept;
  logic       keep;
  logic       push;
  logic       pop;
  req_t       incoming;

  assign full   = (count_q == 2'd2);
  assign busy_o = full;
  assign accept = start_i && !full;

  always_comb begin
    incoming.idx   = ADDR_W'(weight_index_i);
    incoming.value = value_i;
    if (mode_i) begin
      incoming.kind = KIND_FEATURE;
      keep          = 1'b1;
    end else begin
      incoming.kind = KIND_WRITE;
      keep          = (32'(weight_index_i) < STORE_DEPTH);
    end
  end

  assign push        = accept && keep;
  assign req_valid_o = (count_q != 2'd0);
  assign req_o       = slot_q[rd_ptr_q];
  assign pop         = req_valid_o && req_ready_i;

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop  ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= incoming;
    end
  end

endmodule

// ===== rtl/mlp_back.sv =====
// Back end: weight store, per-neuron accumulation, tanh output stage.
module mlp_back import mlp_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_index_i,
  input  logic [CFG_W-1:0]         cfg_wdata_i,
  input  logic                     req_valid_i,
  input  req_t                     req_i,
  output logic                     req_ready_o,
  output logic                     valid_o,
  output logic signed [PRED_W-1:0] prediction_o,
  output logic                     saturated_o
);

  state_e state_q, state_d;

  logic [FC_W-1:0]    nf_q;
  logic [CNT_W-1:0]   nn_q;
  logic [FC_W-1:0]    fc_q;
  logic [STRIDE_W-1:0] stride;
  logic [CFG_W-1:0]   cfg_clamped;

  logic [VAL_W-1:0]   mem_q [STORE_DEPTH];
  logic [VAL_W-1:0]   rdata_q;
  logic               mem_re;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_raddr;

  logic signed [ACC_W-1:0] acc_q [MAX_NEURONS];

  logic signed [VAL_W-1:0] x_q;
  logic [ADDR_W-1:0]  addr_q;
  logic [CNT_W-1:0]   iss_q;
  logic               issuing;
  logic               s1_v_q, s2_v_q;
  logic [K_W-1:0]     s1_k_q, s2_k_q;
  logic signed [2*VAL_W-1:0] prod_q;
  logic               feat_done;
  logic               take;
  logic               row_end;

  logic [CNT_W-1:0]   k_q;
  logic [ADDR_W-1:0]  fbase_q;
  logic signed [VAL_W-1:0] outw_q;
  logic [O_W-1:0]     o_q;
  logic signed [TH_W-1:0] ti_q;
  logic signed [DG_W-1:0] dg_q;
  logic signed [TH_W-1:0] th_q;
  logic signed [VAL_W+TH_W-1:0] wt_q;
  logic signed [TOT_W-1:0] total_q;

  logic signed [Z_W-1:0] z;
  logic signed [Z_W-1:0] zc;
  logic [TAB_IDX_W-1:0] ti0, ti1;
  logic signed [TH_W:0] dtab;
  logic signed [DG_W:0] dg_rnd;
  logic signed [TOT_W:0] rnd;
  logic signed [31:0]  qx;

  logic                    valid_q;
  logic signed [PRED_W-1:0] pred_q;
  logic                    sat_q;

  localparam logic signed [Z_W-1:0] Z_LIM = Z_W'(64'sd1 <<< (O_W - 1));
  localparam logic signed [31:0] PRED_MAX = 32'sd8388607;
  localparam logic signed [31:0] PRED_MIN = -32'sd8388608;

  // ---------------- configuration ----------------
  always_comb begin
    if (cfg_wdata_i == '0) begin
      cfg_clamped = CFG_W'(1);
    end else if (cfg_index_i == REG_NUM_FEATURES && 32'(cfg_wdata_i) > MAX_FEATURES) begin
      cfg_clamped = CFG_W'(MAX_FEATURES);
    end else if (cfg_index_i == REG_NUM_NEURONS && 32'(cfg_wdata_i) > MAX_NEURONS) begin
      cfg_clamped = CFG_W'(MAX_NEURONS);
    end else begin
      cfg_clamped = cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nf_q <= FC_W'(1);
      nn_q <= CNT_W'(1);
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_NUM_FEATURES) begin
        nf_q <= FC_W'(cfg_clamped);
      end else begin
        nn_q <= CNT_W'(cfg_clamped);
      end
    end
  end

  assign stride = STRIDE_W'(nf_q) + STRIDE_W'(2);

  // ---------------- control ----------------
  assign take      = req_valid_i && (state_q == ST_IDLE);
  assign issuing   = (state_q == ST_FEAT) && (iss_q < nn_q);
  assign feat_done = (state_q == ST_FEAT) && !issuing && !s1_v_q && !s2_v_q;
  assign row_end   = (FC_W'(fc_q + 1'b1) >= nf_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (take && req_i.kind == KIND_FEATURE) begin
          if (fc_q < nf_q) begin
            state_d = ST_FEAT;
          end else begin
            state_d = ST_RD_OUT;
          end
        end
      end
      ST_FEAT: begin
        if (feat_done) begin
          state_d = row_end ? ST_RD_OUT : ST_IDLE;
        end
      end
      ST_RD_OUT:  state_d = ST_RD_BIAS;
      ST_RD_BIAS: state_d = ST_Z;
      ST_Z:       state_d = ST_LUT;
      ST_LUT:     state_d = ST_TANH;
      ST_TANH:    state_d = ST_MUL;
      ST_MUL:     state_d = ST_SUM;
      ST_SUM: begin
        state_d = (CNT_W'(k_q + 1'b1) >= nn_q) ? ST_OUT : ST_RD_OUT;
      end
      ST_OUT:     state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready_o = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_raddr   = addr_q;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        mem_we      = take && (req_i.kind == KIND_WRITE);
      end
      ST_FEAT: begin
        mem_re    = issuing;
        mem_raddr = addr_q;
      end
      ST_RD_OUT: begin
        mem_re    = 1'b1;
        mem_raddr = fbase_q;
      end
      ST_RD_BIAS: begin
        mem_re    = 1'b1;
        mem_raddr = ADDR_W'(fbase_q + 1'b1);
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------- weight store ----------------
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[req_i.idx] <= req_i.value;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  // ---------------- feature pass: read, multiply, accumulate ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q   <= '0;
      iss_q  <= '0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      for (int i = 0; i < MAX_NEURONS; i++) begin
        acc_q[i] <= '0;
      end
    end else begin
      s1_v_q <= issuing;
      s2_v_q <= s1_v_q;
      if (take && req_i.kind == KIND_FEATURE) begin
        iss_q <= '0;
        if (fc_q >= nf_q) begin
          fc_q <= FC_W'(fc_q + 1'b1);
        end
      end
      if (issuing) begin
        iss_q <= CNT_W'(iss_q + 1'b1);
      end
      if (feat_done) begin
        fc_q <= FC_W'(fc_q + 1'b1);
      end
      if (s2_v_q) begin
        acc_q[s2_k_q] <= acc_q[s2_k_q] + ACC_W'(prod_q);
      end
      if (state_q == ST_OUT) begin
        fc_q <= '0;
        for (int i = 0; i < MAX_NEURONS; i++) begin
          acc_q[i] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      x_q    <= req_i.value;
      addr_q <= ADDR_W'(fc_q) + ADDR_W'(2);
    end else if (issuing) begin
      addr_q <= ADDR_W'(addr_q + stride);
    end
    s1_k_q <= iss_q[K_W-1:0];
    s2_k_q <= s1_k_q;
    prod_q <= x_q * $signed(rdata_q);
  end

  // ---------------- output pass, one neuron at a time ----------------
  always_comb begin
    z = ACC_W'(acc_q[k_q[K_W-1:0]]) + (Z_W'($signed(rdata_q)) <<< 12);
    if (z < -Z_LIM) begin
      zc = -Z_LIM;
    end else if (z >= Z_LIM) begin
      zc = Z_LIM - Z_W'(1);
    end else begin
      zc = z;
    end
    ti0    = TAB_IDX_W'(o_q[O_W-1 -: TANH_LOG2]);
    ti1    = TAB_IDX_W'(ti0 + 1'b1);
    dtab   = (TH_W+1)'(TANH_TAB[ti1]) - (TH_W+1)'(TANH_TAB[ti0]);
    dg_rnd = (DG_W+1)'(dg_q) + ((DG_W+1)'(1) <<< (FRAC_W - 1));
    rnd    = (TOT_W+1)'(total_q) + (TOT_W+1)'(2048);
    qx     = 32'(rnd >>> 12);
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_RD_BIAS: outw_q <= $signed(rdata_q);
      ST_Z:       o_q    <= O_W'(zc + Z_LIM);
      ST_LUT: begin
        ti_q <= TANH_TAB[ti0];
        dg_q <= DG_W'(dtab * $signed({1'b0, o_q[FRAC_W-1:0]}));
      end
      ST_TANH:    th_q <= ti_q + TH_W'(dg_rnd >>> FRAC_W);
      ST_MUL:     wt_q <= outw_q * th_q;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q     <= '0;
      fbase_q <= '0;
      total_q <= '0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= (state_q == ST_OUT);
      if (state_q != ST_RD_OUT && state_d == ST_RD_OUT) begin
        if (state_q != ST_SUM) begin
          k_q     <= '0;
          fbase_q <= '0;
          total_q <= '0;
        end
      end
      if (state_q == ST_SUM) begin
        total_q <= total_q + TOT_W'(wt_q);
        k_q     <= CNT_W'(k_q + 1'b1);
        fbase_q <= ADDR_W'(fbase_q + stride);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT) begin
      if (qx > PRED_MAX) begin
        pred_q <= PRED_W'(PRED_MAX);
        sat_q  <= 1'b1;
      end else if (qx < PRED_MIN) begin
        pred_q <= PRED_W'(PRED_MIN);
        sat_q  <= 1'b1;
      end else begin
        pred_q <= PRED_W'(qx);
        sat_q  <= 1'b0;
      end
    end
  end

  assign valid_o      = valid_q;
  assign prediction_o = pred_q;
  assign saturated_o  = sat_q;

`ifndef SYNTHESIS
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |=> !valid_q) else $error("result strobe held longer than one cycle");

  a_sat_extreme: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && sat_q) |-> (pred_q == PRED_W'(PRED_MAX) || pred_q == PRED_W'(PRED_MIN)))
    else $error("saturation flag without clipped prediction");

  a_fc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fc_q) <= MAX_FEATURES) else $error("feature count overran");

  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q || s2_v_q) |-> !req_ready_o) else $error("request taken during feature pass");
`endif

endmodule
